>>> hdl/mmrp_pkg.sv
// shared types, codes and constants of the mixer meter reply parser
`timescale 1ns / 1ps
`default_nettype none

package mmrp_pkg;

  // parse position within one reply
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_PORT_HI = 4'd1,
    PH_PORT_LO = 4'd2,
    PH_MIXER   = 4'd3,
    PH_COUNT   = 4'd4,
    PH_DIR     = 4'd5,
    PH_NVALS   = 4'd6,
    PH_LVL_HI  = 4'd7,
    PH_LVL_LO  = 4'd8
  } phase_t;

  // record kinds on the output channel
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_VALUE  = 2'd2;

  // block directions that produce records
  localparam logic [1:0] DIR_IN  = 2'd1;
  localparam logic [1:0] DIR_OUT = 2'd2;

  // depth of the record queue between parser and output stage
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // compact record as held in the queue; aux is the block count of a
  // header record or the channel number of a value record
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  version;
    logic [13:0] port_id;
    logic [7:0]  mixer_output;
    logic [7:0]  aux;
    logic [1:0]  direction;
    logic [13:0] level;
  } q_entry_t;

endpackage

`default_nettype wire

>>> hdl/mmrp_if.sv
// valid/ready channel interfaces for payload bytes and parsed records
`timescale 1ns / 1ps
`default_nettype none

interface mmrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_message;

  modport source(output valid, output data_byte, output start_of_message, input ready);
  modport sink(input valid, input data_byte, input start_of_message, output ready);
endinterface

interface mmrp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [7:0]  version;
  logic [13:0] port_id;
  logic [7:0]  mixer_output;
  logic [7:0]  block_count;
  logic [1:0]  direction;
  logic [7:0]  channel;
  logic [13:0] level;

  modport source(output valid, output record_kind, output version, output port_id,
                 output mixer_output, output block_count, output direction,
                 output channel, output level, input ready);
  modport sink(input valid, input record_kind, input version, input port_id,
               input mixer_output, input block_count, input direction,
               input channel, input level, output ready);
endinterface

`default_nettype wire

>>> hdl/mixer_meter_reply_parser_top.sv
// Mixer meter reply parser: payload bytes in, header, block-start and
// meter value records out.
//
// rx carries one payload byte per beat; start_of_message marks the version
// byte and restarts the parse at any point. tx carries one record per beat:
// a header record after the block count byte, a block-start record for
// input or output blocks, and one value record per meter value of those
// blocks, channels counted from 1. Bytes of other blocks and bytes after
// the last block give no record.
// A record completed by a taken byte is written into the record queue and then
// moves to the output register before it is valid on tx. Throughput: one byte
// per cycle while the record queue has a free slot.
// The parser feeds a short record queue that the output register drains;
// when tx stalls the queue fills, and rx.ready drops once it is full.
// Reset (synchronous, rst high) returns the parser to waiting for a start
// byte, empties the queue and drops tx.valid.
`timescale 1ns / 1ps
`default_nettype none

module mixer_meter_reply_parser_top
  import mmrp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  mmrp_in_if.sink    rx,
  mmrp_out_if.source tx
);

  logic     push;
  logic     q_ready;
  logic     q_valid;
  logic     pop;
  q_entry_t wr_entry;
  q_entry_t rd_entry;

  // byte parser
  mmrp_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (rx.valid),
    .in_ready         (rx.ready),
    .data_byte        (rx.data_byte),
    .start_of_message (rx.start_of_message),
    .q_ready          (q_ready),
    .push             (push),
    .entry            (wr_entry)
  );

  // record queue
  mmrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .wr_ready (q_ready),
    .pop      (pop),
    .rd_entry (rd_entry),
    .rd_valid (q_valid)
  );

  // output stage
  mmrp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (rd_entry),
    .pop     (pop),
    .tx      (tx)
  );

endmodule

`default_nettype wire

>>> hdl/mmrp_front.sv
// byte parser: tracks the reply layout and builds records for the queue
`timescale 1ns / 1ps
`default_nettype none

module mmrp_front
  import mmrp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic     start_of_message,
  input  wire logic     q_ready,
  output logic          push,
  output q_entry_t      entry
);

  phase_t      phase, phase_next;
  logic [7:0]  header_version;
  logic [6:0]  port_high;
  logic [13:0] header_port;
  logic [7:0]  header_mixer;
  logic [7:0]  blocks_left;
  logic [1:0]  block_direction;
  logic [7:0]  values_left;
  logic [7:0]  channel_count;
  logic [6:0]  level_high;

  logic       fire;
  logic [6:0] b7;
  logic       emit;
  logic       last_block;
  logic       dir_live;
  logic       byte_dir_live;

  // every byte yields at most one record, so a free queue slot is enough
  assign in_ready      = q_ready;
  assign fire          = in_valid && in_ready;
  assign b7            = data_byte[6:0];
  assign last_block    = (blocks_left == 8'd1);
  assign dir_live      = (block_direction == DIR_IN) || (block_direction == DIR_OUT);
  assign byte_dir_live = (data_byte[1:0] == DIR_IN) || (data_byte[1:0] == DIR_OUT);

  // next parse position
  always_comb begin
    phase_next = phase;
    if (start_of_message) begin
      phase_next = PH_PORT_HI;
    end else begin
      unique case (phase)
        PH_IDLE:    phase_next = PH_IDLE;
        PH_PORT_HI: phase_next = PH_PORT_LO;
        PH_PORT_LO: phase_next = PH_MIXER;
        PH_MIXER:   phase_next = PH_COUNT;
        PH_COUNT:   phase_next = (data_byte == 8'd0) ? PH_IDLE : PH_DIR;
        PH_DIR:     phase_next = PH_NVALS;
        PH_NVALS: begin
          if (data_byte != 8'd0) begin
            phase_next = PH_LVL_HI;
          end else begin
            phase_next = last_block ? PH_IDLE : PH_DIR;
          end
        end
        PH_LVL_HI:  phase_next = PH_LVL_LO;
        PH_LVL_LO: begin
          if (values_left != 8'd1) begin
            phase_next = PH_LVL_HI;
          end else begin
            phase_next = last_block ? PH_IDLE : PH_DIR;
          end
        end
        default:    phase_next = PH_IDLE;
      endcase
    end
  end

  // record built from the current byte
  always_comb begin
    emit               = 1'b0;
    entry.kind         = KIND_HEADER;
    entry.version      = header_version;
    entry.port_id      = header_port;
    entry.mixer_output = header_mixer;
    entry.aux          = 8'd0;
    entry.direction    = block_direction;
    entry.level        = {level_high, b7};
    if (!start_of_message) begin
      unique case (phase)
        PH_COUNT: begin
          emit       = 1'b1;
          entry.kind = KIND_HEADER;
          entry.aux  = data_byte;
        end
        PH_DIR: begin
          emit            = byte_dir_live;
          entry.kind      = KIND_START;
          entry.direction = data_byte[1:0];
        end
        PH_LVL_LO: begin
          emit       = dir_live;
          entry.kind = KIND_VALUE;
          entry.aux  = 8'(channel_count + 8'd1);
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  assign push = fire && emit;

  // parse state and header fields
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      header_version  <= 8'd0;
      port_high       <= 7'd0;
      header_port     <= 14'd0;
      header_mixer    <= 8'd0;
      blocks_left     <= 8'd0;
      block_direction <= 2'd0;
      values_left     <= 8'd0;
      channel_count   <= 8'd0;
      level_high      <= 7'd0;
    end else if (fire) begin
      phase <= phase_next;
      if (start_of_message) begin
        header_version <= data_byte;
      end else begin
        case (phase)
          PH_PORT_HI: port_high <= b7;
          PH_PORT_LO: header_port <= {port_high, b7};
          PH_MIXER:   header_mixer <= data_byte;
          PH_COUNT:   blocks_left <= data_byte;
          PH_DIR:     block_direction <= data_byte[1:0];
          PH_NVALS: begin
            values_left   <= data_byte;
            channel_count <= 8'd0;
            if (data_byte == 8'd0) begin
              blocks_left <= 8'(blocks_left - 8'd1);
            end
          end
          PH_LVL_HI:  level_high <= b7;
          PH_LVL_LO: begin
            channel_count <= 8'(channel_count + 8'd1);
            values_left   <= 8'(values_left - 8'd1);
            if (values_left == 8'd1) begin
              blocks_left <= 8'(blocks_left - 8'd1);
            end
          end
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  // a block count byte always yields a header record
  a_count_emits: assert property (@(posedge clk) disable iff (rst)
    (fire && !start_of_message && phase == PH_COUNT) |-> push)
    else $error("count byte accepted without header record");

  // value records only for live directions
  a_value_dir: assert property (@(posedge clk) disable iff (rst)
    (push && entry.kind == KIND_VALUE) |->
      (entry.direction == DIR_IN || entry.direction == DIR_OUT))
    else $error("value record with dropped direction");
`endif

endmodule

`default_nettype wire

>>> hdl/mmrp_queue.sv
// short record queue between parser and output stage
`timescale 1ns / 1ps
`default_nettype none

module mmrp_queue
  import mmrp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire q_entry_t wr_entry,
  output logic          wr_ready,
  input  wire logic     pop,
  output q_entry_t      rd_entry,
  output logic          rd_valid
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t          slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

`ifndef SYNTHESIS
  // the parser never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CNT_W'(DEPTH)) || pop)
    else $error("record pushed into full queue");

  // the output stage never reads an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("record popped from empty queue");
`endif

endmodule

`default_nettype wire

>>> hdl/mmrp_back.sv
// output stage: expands queued records into result beats and holds them
`timescale 1ns / 1ps
`default_nettype none

module mmrp_back
  import mmrp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     q_valid,
  input  wire q_entry_t q_entry,
  output logic          pop,
  mmrp_out_if.source    tx
);

  logic        is_header;
  logic        is_value;
  logic        load;

  assign is_header = (q_entry.kind == KIND_HEADER);
  assign is_value  = (q_entry.kind == KIND_VALUE);
  assign load      = q_valid && (!tx.valid || tx.ready);
  assign pop       = load;

  // valid flag of the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (load) begin
      tx.valid <= 1'b1;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  // payload, with the fields a kind does not use cleared to zero
  always_ff @(posedge clk) begin
    if (load) begin
      tx.record_kind  <= q_entry.kind;
      tx.version      <= q_entry.version;
      tx.port_id      <= q_entry.port_id;
      tx.mixer_output <= q_entry.mixer_output;
      tx.block_count  <= is_header ? q_entry.aux : 8'd0;
      tx.direction    <= is_header ? 2'd0 : q_entry.direction;
      tx.channel      <= is_value ? q_entry.aux : 8'd0;
      tx.level        <= is_value ? q_entry.level : 14'd0;
    end
  end

`ifndef SYNTHESIS
  // a waiting queue record moves out as soon as the register frees up
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (q_valid && (!tx.valid || tx.ready)) |=> tx.valid)
    else $error("queued record not moved to output register");
`endif

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// self-checking bench for the mixer meter reply parser: byte stream in, records checked
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import mmrp_pkg::*;

  // direction code that is parsed but gives no records
  localparam logic [1:0] DIR_OTHER = 2'd3;
  localparam logic [1:0] DIR_NONE  = 2'd0;

  typedef struct packed {
    logic [7:0] data;
    logic       sof;
  } reply_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  version;
    logic [13:0] port_id;
    logic [7:0]  mixer_output;
    logic [7:0]  block_count;
    logic [1:0]  direction;
    logic [7:0]  channel;
    logic [13:0] level;
  } meter_record_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mmrp_in_if  rx_bus ();
  mmrp_out_if tx_bus ();

  mixer_meter_reply_parser_top uut (
    .clk(clk),
    .rst(rst),
    .rx (rx_bus),
    .tx (tx_bus)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  reply_beat_t   reply_bytes[$];
  meter_record_t expected_records[$];
  int            beats_taken = 0;
  int            total_beats = 0;
  int            mismatches = 0;
  int            records_seen = 0;
  int            kind_seen[3] = '{0, 0, 0};

  // parser shadow state
  phase_t      sh_phase = PH_IDLE;
  logic [7:0]  sh_version = '0;
  logic [6:0]  sh_port_hi = '0;
  logic [13:0] sh_port = '0;
  logic [7:0]  sh_mixer = '0;
  logic [7:0]  sh_blocks_left = '0;
  logic [1:0]  sh_dir = '0;
  logic [7:0]  sh_vals_left = '0;
  logic [7:0]  sh_chan = '0;
  logic [6:0]  sh_level_hi = '0;

  function automatic reply_beat_t mk_beat(input logic [7:0] data, input logic sof);
    reply_beat_t bt;
    bt.data = data;
    bt.sof  = sof;
    return bt;
  endfunction

  // append one byte to the stimulus stream
  function automatic void add_beat(input logic [7:0] data, input logic sof);
    reply_bytes.insert(reply_bytes.size(), mk_beat(data, sof));
  endfunction

  // append one record to the expected stream
  function automatic void add_record(input meter_record_t rec);
    expected_records.insert(expected_records.size(), rec);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic meter_record_t mk_record(input logic [1:0] kind, input logic [7:0] count,
                                              input logic [1:0] dir, input logic [7:0] chan,
                                              input logic [13:0] lvl);
    meter_record_t rec;
    rec.kind         = kind;
    rec.version      = sh_version;
    rec.port_id      = sh_port;
    rec.mixer_output = sh_mixer;
    rec.block_count  = count;
    rec.direction    = dir;
    rec.channel      = chan;
    rec.level        = lvl;
    return rec;
  endfunction

  function automatic void close_block();
    sh_blocks_left = sh_blocks_left - 8'd1;
    sh_phase = (sh_blocks_left == 8'd0) ? PH_IDLE : PH_DIR;
  endfunction

  // advance the shadow parser by one byte and queue any record it yields
  function automatic void parse_reply_byte(input logic [7:0] b, input logic sof);
    logic keep;
    keep = (sh_dir == DIR_IN) || (sh_dir == DIR_OUT);
    if (sof) begin
      sh_version = b;
      sh_phase   = PH_PORT_HI;
    end else begin
      case (sh_phase)
        PH_PORT_HI: begin
          sh_port_hi = b[6:0];
          sh_phase   = PH_PORT_LO;
        end
        PH_PORT_LO: begin
          sh_port  = {sh_port_hi, b[6:0]};
          sh_phase = PH_MIXER;
        end
        PH_MIXER: begin
          sh_mixer = b;
          sh_phase = PH_COUNT;
        end
        PH_COUNT: begin
          sh_blocks_left = b;
          sh_phase = (b == 8'd0) ? PH_IDLE : PH_DIR;
          add_record(mk_record(KIND_HEADER, b, DIR_NONE, 8'd0, 14'd0));
        end
        PH_DIR: begin
          sh_dir   = b[1:0];
          sh_phase = PH_NVALS;
          if (sh_dir == DIR_IN || sh_dir == DIR_OUT)
            add_record(mk_record(KIND_START, 8'd0, sh_dir, 8'd0, 14'd0));
        end
        PH_NVALS: begin
          sh_vals_left = b;
          sh_chan      = 8'd0;
          if (b == 8'd0) close_block();
          else sh_phase = PH_LVL_HI;
        end
        PH_LVL_HI: begin
          sh_level_hi = b[6:0];
          sh_phase    = PH_LVL_LO;
        end
        PH_LVL_LO: begin
          sh_chan = sh_chan + 8'd1;
          if (keep)
            add_record(mk_record(KIND_VALUE, 8'd0, sh_dir, sh_chan,
                                 {sh_level_hi, b[6:0]}));
          sh_vals_left = sh_vals_left - 8'd1;
          if (sh_vals_left == 8'd0) close_block();
          else sh_phase = PH_LVL_HI;
        end
        default: sh_phase = PH_IDLE;
      endcase
    end
  endfunction

  // byte driver with random gaps and quiet stretches
  reply_beat_t cur_beat;
  int          send_gap = 0;
  bit          send_quiet = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rx_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (rx_bus.valid && rx_bus.ready) begin
        parse_reply_byte(cur_beat.data, cur_beat.sof);
        beats_taken++;
        if ($urandom_range(0, 63) == 0) send_quiet = !send_quiet;
      end
      if (!rx_bus.valid || rx_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          rx_bus.valid <= 1'b0;
        end else if (reply_bytes.size() != 0) begin
          cur_beat = reply_bytes.pop_front();
          rx_bus.valid            <= 1'b1;
          rx_bus.data_byte        <= cur_beat.data;
          rx_bus.start_of_message <= cur_beat.sof;
          send_gap = send_quiet ? 0 : pick_gap();
        end else begin
          rx_bus.valid <= 1'b0;
        end
      end
    end
  end

  // record monitor with random back-pressure
  int            stall_left = 0;
  bit            recv_quiet = 1'b0;
  meter_record_t got_rec;
  meter_record_t want_rec;

  always @(posedge clk) begin
    if (rst) begin
      tx_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (tx_bus.valid && tx_bus.ready) begin
        got_rec.kind         = tx_bus.record_kind;
        got_rec.version      = tx_bus.version;
        got_rec.port_id      = tx_bus.port_id;
        got_rec.mixer_output = tx_bus.mixer_output;
        got_rec.block_count  = tx_bus.block_count;
        got_rec.direction    = tx_bus.direction;
        got_rec.channel      = tx_bus.channel;
        got_rec.level        = tx_bus.level;
        records_seen++;
        if (got_rec.kind <= KIND_VALUE) kind_seen[got_rec.kind]++;
        if (expected_records.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected record kind=%0d ver=%0d port=%0d mix=%0d",
                     $time, got_rec.kind, got_rec.version, got_rec.port_id,
                     got_rec.mixer_output,
                     "  cnt=%0d dir=%0d ch=%0d lvl=%0d",
                     got_rec.block_count, got_rec.direction,
                     got_rec.channel, got_rec.level);
        end else begin
          want_rec = expected_records.pop_front();
          if (got_rec.kind !== want_rec.kind || got_rec.version !== want_rec.version ||
              got_rec.port_id !== want_rec.port_id ||
              got_rec.mixer_output !== want_rec.mixer_output ||
              got_rec.block_count !== want_rec.block_count ||
              got_rec.direction !== want_rec.direction ||
              got_rec.channel !== want_rec.channel || got_rec.level !== want_rec.level) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] record mismatch", $time);
              $display("  expected kind=%0d ver=%0d port=%0d mix=%0d",
                       want_rec.kind, want_rec.version, want_rec.port_id,
                       want_rec.mixer_output,
                       " cnt=%0d dir=%0d ch=%0d lvl=%0d",
                       want_rec.block_count, want_rec.direction,
                       want_rec.channel, want_rec.level);
              $display("  actual   kind=%0d ver=%0d port=%0d mix=%0d",
                       got_rec.kind, got_rec.version, got_rec.port_id,
                       got_rec.mixer_output,
                       " cnt=%0d dir=%0d ch=%0d lvl=%0d",
                       got_rec.block_count, got_rec.direction,
                       got_rec.channel, got_rec.level);
            end
          end
        end
        if ($urandom_range(0, 63) == 0) recv_quiet = !recv_quiet;
      end
      if (stall_left > 0) begin
        stall_left--;
        tx_bus.ready <= 1'b0;
      end else begin
        tx_bus.ready <= 1'b1;
        if (!recv_quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    reply_beat_t msg[$];
    int          n_random;
    int          mode;
    int          n_blocks;
    int          n_vals;
    int          cut_len;
    bit          long_block_done;
    logic [1:0]  blk_dir;

    n_random = 0;
    long_block_done = 1'b0;
    rx_bus.valid            = 1'b0;
    rx_bus.data_byte        = 8'h00;
    rx_bus.start_of_message = 1'b0;
    tx_bus.ready            = 1'b0;

    // stray byte before any start
    add_beat(8'h5A, 1'b0);
    // full reply: extreme header bytes, input block, empty output block, dropped block
    add_beat(8'hFF, 1'b1);
    add_beat(8'hFF, 1'b0);
    add_beat(8'h80, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'd3, 1'b0);
    add_beat({6'h3F, DIR_IN}, 1'b0);
    add_beat(8'd2, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'h80, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat({6'h00, DIR_OUT}, 1'b0);
    add_beat(8'd0, 1'b0);
    add_beat({6'h15, DIR_OTHER}, 1'b0);
    add_beat(8'd1, 1'b0);
    add_beat(8'h12, 1'b0);
    add_beat(8'h34, 1'b0);
    // trailing byte after the last block
    add_beat(8'h77, 1'b0);
    // all-zero header, zero block count
    repeat (5) add_beat(8'h00, 1'b0);
    reply_bytes[19].sof = 1'b1;
    // reply cut inside a value, restarted by the next start
    add_beat(8'h42, 1'b1);
    add_beat(8'h05, 1'b0);
    add_beat(8'h06, 1'b0);
    add_beat(8'h07, 1'b0);
    add_beat(8'd2, 1'b0);
    add_beat({6'h00, DIR_OUT}, 1'b0);
    add_beat(8'd3, 1'b0);
    add_beat(8'h01, 1'b0);

    // random replies: mostly well formed, some cut short, some noise
    while (n_random < 500) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        repeat ($urandom_range(1, 4)) begin
          add_beat(8'($urandom), 1'b0);
          n_random++;
        end
      end else begin
        msg.delete();
        n_blocks = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
        msg.insert(msg.size(), mk_beat(8'($urandom), 1'b1));
        repeat (3) msg.insert(msg.size(), mk_beat(8'($urandom), 1'b0));
        msg.insert(msg.size(), mk_beat((mode == 1) ? 8'($urandom) : 8'(n_blocks), 1'b0));
        repeat (n_blocks) begin
          blk_dir = 2'($urandom);
          if (!long_block_done && n_random > 200) begin
            // one long input block runs the channel number to its top
            long_block_done = 1'b1;
            n_vals  = 255;
            blk_dir = DIR_IN;
          end else begin
            n_vals = $urandom_range(0, 4);
          end
          msg.insert(msg.size(), mk_beat({6'($urandom), blk_dir}, 1'b0));
          msg.insert(msg.size(), mk_beat(8'(n_vals), 1'b0));
          repeat (2 * n_vals) msg.insert(msg.size(), mk_beat(8'($urandom), 1'b0));
        end
        if (mode == 1) begin
          cut_len = $urandom_range(1, msg.size() - 1);
          while (msg.size() > cut_len) void'(msg.pop_back());
        end else if (mode == 2) begin
          repeat ($urandom_range(1, 3)) msg.insert(msg.size(), mk_beat(8'($urandom), 1'b0));
        end
        n_random += msg.size();
        foreach (msg[i]) reply_bytes.insert(reply_bytes.size(), msg[i]);
      end
    end
    total_beats = reply_bytes.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (beats_taken < total_beats) @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d reply bytes and %0d records", total_beats, records_seen);
    $display("  (%0d header, %0d block start, %0d value)",
             kind_seen[KIND_HEADER], kind_seen[KIND_START], kind_seen[KIND_VALUE]);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("PASS mixer_meter_reply_parser_top");
    end else begin
      $display("FAIL mixer_meter_reply_parser_top");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout: %0d of %0d bytes taken, %0d records pending",
             beats_taken, total_beats, expected_records.size());
    $display("FAIL mixer_meter_reply_parser_top");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hdl/mmrp_pkg.sv
hdl/mmrp_if.sv
hdl/mmrp_front.sv
hdl/mmrp_queue.sv
hdl/mmrp_back.sv
hdl/mixer_meter_reply_parser_top.sv
sim/tb_top.sv
